// ===== design/vfrb_pkg.sv =====
package vfrb_pkg;

    // Store geometry. The word address width follows from the store size.
    localparam int STORE_BYTES = 4096;
    localparam int STORE_WORDS = STORE_BYTES / 4;
    localparam int WORD_AW     = $clog2(STORE_WORDS);
    localparam int LANES       = 4;
    localparam int LANE_AW     = 2;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 12;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;

    // Width of byte counts and byte addresses inside the store.
    localparam int CALC_W = (WORD_AW + 3 > CFG_W + 1) ? WORD_AW + 3 : CFG_W + 1;

    localparam int BUFFER_BYTES_RESET = 4096;
    localparam int SAFE_SPACE_RESET   = 1024;
    localparam int MIN_BUFFER_BYTES   = 64;
    localparam int FRAME_OVERHEAD     = 8;
    localparam int LEN_WORD_BYTES     = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_SPACE   = 1'b1;

    typedef enum logic [2:0] {
        KIND_WRITE   = 3'd0,
        KIND_GET     = 3'd1,
        KIND_READ    = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_DISCARD = 3'd4,
        KIND_CANCEL  = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_RETRY     = 3'd1,
        STATUS_TOO_LONG  = 3'd2,
        STATUS_CANCELLED = 3'd3,
        STATUS_NO_FRAME  = 3'd4
    } status_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data_in;
        logic              end_of_frame;
        logic [LEN_W-1:0]  byte_offset;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] data_out;
    } result_t;

    // Usable store size: whole words, no more than the store, no less than the minimum.
    function automatic logic [CALC_W-1:0] clamp_bytes(input logic [CFG_W-1:0] value);
        logic [CALC_W-1:0] b;
        b = CALC_W'({value[CFG_W-1:2], 2'b00});
        if (b > CALC_W'(STORE_BYTES)) begin
            b = CALC_W'(STORE_BYTES);
        end
        if (b < CALC_W'(MIN_BUFFER_BYTES)) begin
            b = CALC_W'(MIN_BUFFER_BYTES);
        end
        return b;
    endfunction

    // Room needed before a frame may start; never below the frame overhead.
    function automatic logic [CALC_W-1:0] clamp_safe(input logic [CFG_W-1:0] value);
        logic [CALC_W-1:0] s;
        s = CALC_W'(value);
        if (s < CALC_W'(FRAME_OVERHEAD)) begin
            s = CALC_W'(FRAME_OVERHEAD);
        end
        return s;
    endfunction

    // Words taken by a frame of the given length, length word included.
    function automatic logic [WORD_AW-1:0] frame_words(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] t;
        t = {1'b0, len} + (LEN_W + 1)'(7);
        return WORD_AW'(t >> 2);
    endfunction

endpackage

// ===== design/vfrb_ram.sv =====
module vfrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // A read of the address being written returns the new data.
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
            end else begin
                rd_data_reg <= mem_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/variable_frame_ring_buffer_unit.sv =====
// Ring store of variable-length frames with a one-byte-per-transfer write side.
// Input transfers (s_valid/s_ready, s_data) carry one command each: append a byte,
// get the oldest frame's length, read a byte of it, release it, discard the open
// frame or cancel. Every input transfer produces exactly one result transfer
// (m_valid/m_ready, m_data) holding a status, the frame length and a data byte.
// Configuration transfers (cfg_valid/cfg_ready) set the usable store size or the
// largest frame and empty the ring; they are meant for an idle block.
// The command is registered while the store is read, and the result then goes into
// the output register once that register is free. One command is taken every cycle
// while the receiver keeps up; the path that sets the pace is the store read of the head
// frame's length, which feeds the read pointer seen by the next command.
// When the receiver stalls, the result holds and the command behind it waits in
// the input register; s_ready drops until the result is taken.
// Reset empties the ring, clears the cancel flag and restores the default sizes.
// The store needs no clearing pass: wrap positions live in registers, and only
// words of closed frames are ever read back.
module variable_frame_ring_buffer_unit
    import vfrb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  item_t                s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output result_t              m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Ring state.
    logic [WORD_AW-1:0] read_word_reg, read_word_next;
    logic [WORD_AW-1:0] write_word_reg, write_word_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic               cancelled_reg, cancelled_next;
    // A pending wrap: the reader must jump to word zero when it reaches wrap_at_reg.
    logic               wrap_valid_reg, wrap_valid_next;
    logic [WORD_AW-1:0] wrap_at_reg, wrap_at_next;
    logic [CALC_W-1:0]  eff_bytes_reg;
    logic [CALC_W-1:0]  eff_safe_reg;

    // Command register and result register.
    logic    item_valid_reg;
    item_t   item_reg;
    logic    m_valid_reg;
    result_t m_data_reg;
    result_t result;

    logic s_accept;
    logic cfg_accept;
    logic advance;

    // Store ports. Length words and data bytes sit in separate memories,
    // the data as four byte lanes so that a byte write needs no read.
    logic                               len_we;
    logic [WORD_AW-1:0]                 len_waddr;
    logic [LEN_W-1:0]                   len_wdata;
    logic [WORD_AW-1:0]                 len_raddr;
    logic [LEN_W-1:0]                   len_q;
    logic                               data_we;
    logic [WORD_AW-1:0]                 data_waddr;
    logic [LANE_AW-1:0]                 data_wlane;
    logic [WORD_AW-1:0]                 data_raddr;
    logic [LANES-1:0][BYTE_W-1:0]       lane_q;
    logic [BYTE_W-1:0]                  byte_q;

    // Locating the head frame for the command in the second stage.
    logic               empty_now;
    logic               wrap_hit;
    logic [WORD_AW-1:0] loc_word;
    logic               located;

    // Write-side checks for the command in the second stage.
    logic [CALC_W-1:0]  used_bytes;
    logic [CALC_W-1:0]  tail_bytes;
    logic               need_wrap;
    logic               refuse_wrap;
    logic [WORD_AW-1:0] w_eff;
    logic [CALC_W-1:0]  gap_bytes;
    logic               gap_fail;
    logic               too_long;
    logic [CALC_W-1:0]  wr_byte_addr;
    logic               wr_in_range;
    logic [LEN_W-1:0]   fill_plus;

    // Pointer view for the command being accepted this cycle.
    logic [WORD_AW-1:0] ahead_read_word;
    logic               ahead_wrap_valid;
    logic [WORD_AW-1:0] ahead_wrap_at;
    logic [WORD_AW-1:0] ahead_loc_word;

    assign advance    = item_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !item_valid_reg || advance;
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    // The store read for a new command uses the pointers as they stand after the
    // command now finishing, so back-to-back commands see each other's effects.
    assign ahead_read_word  = advance ? read_word_next : read_word_reg;
    assign ahead_wrap_valid = advance ? wrap_valid_next : wrap_valid_reg;
    assign ahead_wrap_at    = advance ? wrap_at_next : wrap_at_reg;
    assign ahead_loc_word   = (ahead_wrap_valid && (ahead_read_word == ahead_wrap_at)) ?
                              '0 : ahead_read_word;
    assign len_raddr  = ahead_loc_word;
    assign data_raddr = WORD_AW'(CALC_W'(ahead_loc_word) + CALC_W'(s_data.byte_offset >> 2)
                                 + CALC_W'(1));

    vfrb_ram #(
        .WIDTH (LEN_W),
        .DEPTH (STORE_WORDS)
    ) u_len_ram (
        .clk     (aclk),
        .wr_en   (len_we),
        .wr_addr (len_waddr),
        .wr_data (len_wdata),
        .rd_en   (s_accept),
        .rd_addr (len_raddr),
        .rd_data (len_q)
    );

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        vfrb_ram #(
            .WIDTH (BYTE_W),
            .DEPTH (STORE_WORDS)
        ) u_data_ram (
            .clk     (aclk),
            .wr_en   (data_we && (data_wlane == LANE_AW'(g))),
            .wr_addr (data_waddr),
            .wr_data (item_reg.data_in),
            .rd_en   (s_accept),
            .rd_addr (data_raddr),
            .rd_data (lane_q[g])
        );
    end

    assign byte_q = lane_q[item_reg.byte_offset[LANE_AW-1:0]];

    // Head frame: an equal pair of pointers means empty; a pending wrap at the
    // read pointer sends the reader back to word zero first.
    assign empty_now = (read_word_reg == write_word_reg);
    assign wrap_hit  = wrap_valid_reg && (read_word_reg == wrap_at_reg);
    assign loc_word  = wrap_hit ? '0 : read_word_reg;
    assign located   = !empty_now && (loc_word != write_word_reg);

    // Space check, made only for the first byte of a frame.
    assign used_bytes  = CALC_W'({write_word_reg, 2'b00});
    assign tail_bytes  = (used_bytes > eff_bytes_reg) ? '0 : eff_bytes_reg - used_bytes;
    assign need_wrap   = (fill_reg == '0) && (write_word_reg >= read_word_reg) &&
                         (tail_bytes < eff_safe_reg);
    assign refuse_wrap = need_wrap && (read_word_reg == '0);
    assign w_eff       = need_wrap ? '0 : write_word_reg;
    assign gap_bytes   = CALC_W'({read_word_reg - w_eff, 2'b00});
    assign gap_fail    = (fill_reg == '0) && (w_eff < read_word_reg) &&
                         (gap_bytes < eff_safe_reg);
    assign too_long    = CALC_W'(fill_reg) >= (eff_safe_reg - CALC_W'(FRAME_OVERHEAD));

    assign wr_byte_addr = CALC_W'({w_eff, 2'b00}) + CALC_W'(LEN_WORD_BYTES) + CALC_W'(fill_reg);
    assign wr_in_range  = (wr_byte_addr[CALC_W-1:WORD_AW+2] == '0);
    assign fill_plus    = fill_reg + LEN_W'(1);
    assign data_waddr   = wr_byte_addr[WORD_AW+1:2];
    assign data_wlane   = wr_byte_addr[LANE_AW-1:0];
    assign len_waddr    = w_eff;
    assign len_wdata    = fill_plus;

    always_comb begin
        read_word_next  = read_word_reg;
        write_word_next = write_word_reg;
        fill_next       = fill_reg;
        cancelled_next  = cancelled_reg;
        wrap_valid_next = wrap_valid_reg;
        wrap_at_next    = wrap_at_reg;
        len_we          = 1'b0;
        data_we         = 1'b0;
        result          = '{status: STATUS_OK, frame_length: '0, data_out: '0};

        unique case (item_reg.kind)
            KIND_WRITE: begin
                if (cancelled_reg) begin
                    result.status = STATUS_CANCELLED;
                end else if (refuse_wrap) begin
                    result.status = STATUS_RETRY;
                end else begin
                    // The wrap stands even when the frame is then refused.
                    if (need_wrap) begin
                        write_word_next = '0;
                        wrap_valid_next = 1'b1;
                        wrap_at_next    = write_word_reg;
                    end
                    if (gap_fail) begin
                        result.status = STATUS_RETRY;
                    end else if (too_long) begin
                        result.status = STATUS_TOO_LONG;
                    end else begin
                        data_we   = advance && wr_in_range;
                        fill_next = fill_plus;
                        if (item_reg.end_of_frame) begin
                            len_we          = advance;
                            write_word_next = w_eff + frame_words(fill_plus);
                            fill_next       = '0;
                        end
                    end
                end
            end
            KIND_GET, KIND_READ: begin
                if (cancelled_reg) begin
                    result.status = STATUS_CANCELLED;
                end else if (empty_now) begin
                    result.status = STATUS_RETRY;
                end else begin
                    read_word_next  = loc_word;
                    wrap_valid_next = wrap_valid_reg && !wrap_hit;
                    if (!located) begin
                        result.status = STATUS_RETRY;
                    end else begin
                        result.frame_length = len_q;
                        if (item_reg.kind == KIND_READ) begin
                            if (item_reg.byte_offset >= len_q) begin
                                result.status = STATUS_TOO_LONG;
                            end else begin
                                result.data_out = byte_q;
                            end
                        end
                    end
                end
            end
            KIND_RELEASE: begin
                if (empty_now) begin
                    result.status = STATUS_NO_FRAME;
                end else begin
                    wrap_valid_next = wrap_valid_reg && !wrap_hit;
                    if (!located) begin
                        read_word_next = loc_word;
                        result.status  = STATUS_NO_FRAME;
                    end else begin
                        read_word_next = loc_word + frame_words(len_q);
                    end
                end
            end
            KIND_DISCARD: begin
                fill_next = '0;
            end
            KIND_CANCEL: begin
                cancelled_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_word_reg  <= '0;
            write_word_reg <= '0;
            fill_reg       <= '0;
            cancelled_reg  <= 1'b0;
            wrap_valid_reg <= 1'b0;
            eff_bytes_reg  <= clamp_bytes(CFG_W'(BUFFER_BYTES_RESET));
            eff_safe_reg   <= clamp_safe(CFG_W'(SAFE_SPACE_RESET));
            item_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_accept) begin
                // Either register write empties the ring; the cancel flag stays.
                unique case (cfg_index)
                    REG_BUFFER_BYTES: begin
                        eff_bytes_reg <= clamp_bytes(cfg_data);
                    end
                    REG_SAFE_SPACE: begin
                        eff_safe_reg <= clamp_safe(cfg_data);
                    end
                endcase
                read_word_reg  <= '0;
                write_word_reg <= '0;
                fill_reg       <= '0;
                wrap_valid_reg <= 1'b0;
            end else if (advance) begin
                read_word_reg  <= read_word_next;
                write_word_reg <= write_word_next;
                fill_reg       <= fill_next;
                cancelled_reg  <= cancelled_next;
                wrap_valid_reg <= wrap_valid_next;
            end

            if (s_accept) begin
                item_valid_reg <= 1'b1;
            end else if (advance) begin
                item_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (advance) begin
            m_data_reg  <= result;
            wrap_at_reg <= wrap_at_next;
        end
    end

endmodule

// ===== tb/sv/tb_variable_frame_ring_buffer_unit.sv =====
module tb_variable_frame_ring_buffer_unit;
    import vfrb_pkg::*;

    // The run is stopped at this many clock cycles. The slowest correct run stays
    // far below it, even with the longest sender gaps and receiver stalls.
    localparam int CYCLE_LIMIT = 400000;

    // Command codes outside the defined set. The block must answer them with an
    // all-zero result and leave its state alone.
    localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
    localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

    // Every input of the block holds a known value from time zero.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    item_t                s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    result_t              m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    variable_frame_ring_buffer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the ring. Pointers are kept as plain unsigned integers so that
    // a write pointer landing exactly on the end of a full-size store is held
    // as it is, and words past the end read back as zero.
    logic [31:0]      ring_mem [STORE_WORDS];
    int unsigned      head_word;
    int unsigned      tail_word;
    int unsigned      open_bytes;
    bit               halted;
    logic [CFG_W-1:0] buf_cfg;
    logic [CFG_W-1:0] room_cfg;

    // Results that the block still owes, oldest first.
    result_t     reply_q[$];
    result_t     want;
    int unsigned fail_count     = 0;
    int unsigned sent_count     = 0;
    int unsigned cycle_count    = 0;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_request   = 0;
    int unsigned hold_left      = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow ring
    // ------------------------------------------------------------------

    function automatic logic [31:0] ring_rd(input int unsigned idx);
        return (idx < STORE_WORDS) ? ring_mem[idx] : 32'd0;
    endfunction

    function automatic void ring_wr(input int unsigned idx, input logic [31:0] value);
        if (idx < STORE_WORDS) begin
            ring_mem[idx] = value;
        end
    endfunction

    // Store size in use: whole words, clamped between the minimum and the store.
    function automatic int unsigned usable_bytes();
        int unsigned b;
        b = {buf_cfg[CFG_W-1:2], 2'b00};
        if (b > STORE_WORDS * 4) begin
            b = STORE_WORDS * 4;
        end
        if (b < MIN_BUFFER_BYTES) begin
            b = MIN_BUFFER_BYTES;
        end
        return b;
    endfunction

    // Free room demanded before a frame may start.
    function automatic int unsigned frame_room();
        return (room_cfg < FRAME_OVERHEAD) ? FRAME_OVERHEAD : room_cfg;
    endfunction

    function automatic void empty_ring();
        head_word  = 0;
        tail_word  = 0;
        open_bytes = 0;
        ring_wr(0, 32'd0);
    endfunction

    function automatic void reset_ring_shadow();
        foreach (ring_mem[i]) begin
            ring_mem[i] = 32'd0;
        end
        empty_ring();
        halted   = 1'b0;
        buf_cfg  = CFG_W'(BUFFER_BYTES_RESET);
        room_cfg = CFG_W'(SAFE_SPACE_RESET);
    endfunction

    // Moves the head past a wrap marker and reports the oldest closed frame.
    function automatic bit find_head(output int unsigned len);
        len = 0;
        if (head_word == tail_word) begin
            return 1'b0;
        end
        if (ring_rd(head_word) == 32'd0) begin
            head_word = 0;
            if (head_word == tail_word) begin
                return 1'b0;
            end
        end
        len = ring_rd(head_word) & 32'hFFF;
        return 1'b1;
    endfunction

    // Length of the oldest closed frame without touching the shadow state.
    // Used only to aim read offsets at bytes that exist.
    function automatic int unsigned peek_head_len();
        int unsigned h;
        if (head_word == tail_word) begin
            return 0;
        end
        h = (ring_rd(head_word) == 32'd0) ? 0 : head_word;
        if (h == tail_word) begin
            return 0;
        end
        return ring_rd(h) & 32'hFFF;
    endfunction

    // Appends one byte to the open frame. The room check is made only for the
    // first byte of a frame, where the writer may wrap back to word 0.
    function automatic status_t append_byte(input logic [7:0] d, input logic eof);
        int unsigned s;
        int unsigned b;
        int unsigned used;
        int unsigned gap;
        int unsigned addr;
        logic [31:0] w;
        s = frame_room();
        if (halted) begin
            return STATUS_CANCELLED;
        end
        if (open_bytes == 0) begin
            if (tail_word >= head_word) begin
                b    = usable_bytes();
                used = tail_word * 4;
                gap  = (used > b) ? 0 : b - used;
                if (gap < s) begin
                    if (head_word == 0) begin
                        return STATUS_RETRY;
                    end
                    tail_word = 0;
                    ring_wr(0, 32'd0);
                end
            end
            if (tail_word < head_word && (head_word - tail_word) * 4 < s) begin
                return STATUS_RETRY;
            end
        end
        if (open_bytes >= s - FRAME_OVERHEAD) begin
            return STATUS_TOO_LONG;
        end
        addr = tail_word * 4 + LEN_WORD_BYTES + open_bytes;
        w = ring_rd(addr >> 2);
        w[(addr & 3) * 8 +: 8] = d;
        ring_wr(addr >> 2, w);
        open_bytes = (open_bytes + 1) & 32'hFFF;
        if (eof) begin
            // Close the frame: length word, advance, and a marker at the new tail.
            ring_wr(tail_word, 32'(open_bytes));
            tail_word = tail_word + ((open_bytes + 7) >> 2);
            ring_wr(tail_word, 32'd0);
            open_bytes = 0;
        end
        return STATUS_OK;
    endfunction

    // Expected result of one command, applied to the shadow state.
    function automatic result_t predict_reply(input item_t it);
        result_t     r;
        int unsigned len;
        int unsigned a;
        logic [31:0] w;
        r = '0;
        r.status = STATUS_OK;
        case (it.kind)
            KIND_WRITE: begin
                r.status = append_byte(it.data_in, it.end_of_frame);
            end
            KIND_GET, KIND_READ: begin
                if (halted) begin
                    r.status = STATUS_CANCELLED;
                end else if (!find_head(len)) begin
                    r.status = STATUS_RETRY;
                end else begin
                    r.frame_length = len[LEN_W-1:0];
                    if (it.kind == KIND_READ) begin
                        if (it.byte_offset >= len) begin
                            r.status = STATUS_TOO_LONG;
                        end else begin
                            a = head_word * 4 + LEN_WORD_BYTES + it.byte_offset;
                            w = ring_rd(a >> 2);
                            r.data_out = w[(a & 3) * 8 +: 8];
                        end
                    end
                end
            end
            KIND_RELEASE: begin
                if (!find_head(len)) begin
                    r.status = STATUS_NO_FRAME;
                end else begin
                    head_word = head_word + ((len + 7) >> 2);
                end
            end
            KIND_DISCARD: begin
                open_bytes = 0;
            end
            KIND_CANCEL: begin
                halted = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic item_t mk_item(input logic [2:0] k, input logic [7:0] d,
                                      input logic eof, input logic [LEN_W-1:0] off);
        item_t it;
        it.kind         = kind_t'(k);
        it.data_in      = d;
        it.end_of_frame = eof;
        it.byte_offset  = off;
        return it;
    endfunction

    // Offers one command and waits for its transfer. Valid stays high from the
    // previous transfer when no gap is drawn, so back-to-back commands are
    // offered without a bubble. The expectation is recorded at the accepting edge.
    task automatic send_cmd(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        reply_q.push_back(predict_reply(it));
        if (it.kind <= KIND_CANCEL) begin
            sent_count++;
        end
    endtask

    task automatic send_random_of_kind(input logic [2:0] k);
        send_cmd(mk_item(k, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         LEN_W'($urandom_range(4095))));
    endtask

    // Writes len bytes of random data; the last one carries end of frame if close is set.
    task automatic write_frame(input int unsigned len, input bit close);
        for (int unsigned i = 0; i < len; i++) begin
            send_cmd(mk_item(KIND_WRITE, 8'($urandom_range(255)), close && (i == len - 1),
                             LEN_W'($urandom_range(4095))));
        end
    endtask

    task automatic read_at(input int unsigned off);
        send_cmd(mk_item(KIND_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         LEN_W'(off)));
    endtask

    // Lowers valid after the last transfer and waits until every result is back.
    // Every command yields a result, so an empty queue means an idle block; spare
    // cycles after that cover the pipeline registers anyway.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (reply_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // Register write, only ever made on an idle block. Either register empties the ring.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        if (idx == REG_BUFFER_BYTES) begin
            buf_cfg = value;
        end else begin
            room_cfg = value;
        end
        empty_ring();
    endtask

    // Random traffic shaped as frame sequences: mostly whole frames followed by
    // gets, reads and releases, with open frames dropped by discard, frames that
    // run past the size limit, and a share of random commands as noise.
    task automatic run_frame_traffic(input int unsigned n, input bit allow_cancel);
        int unsigned stop_at;
        int unsigned cap;
        int unsigned short_cap;
        int unsigned len;
        int unsigned pick;
        int unsigned sub;
        int unsigned hl;
        int unsigned off;
        int unsigned k;
        bit          close;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                cap       = (frame_room() > FRAME_OVERHEAD) ? frame_room() - FRAME_OVERHEAD : 1;
                short_cap = (cap < 6) ? cap : 6;
                sub       = $urandom_range(99);
                if (sub < 70) begin
                    len = $urandom_range(1, short_cap);
                end else if (sub < 90) begin
                    len = $urandom_range(1, cap);
                end else begin
                    len = cap + $urandom_range(1, 3);
                end
                close = ($urandom_range(99) >= 12);
                write_frame(len, close);
                if (!close && $urandom_range(1)) begin
                    send_random_of_kind(KIND_DISCARD);
                end
            end else if (pick < 70) begin
                send_random_of_kind(KIND_GET);
                repeat ($urandom_range(1, 4)) begin
                    hl = peek_head_len();
                    if (hl > 0 && $urandom_range(99) < 80) begin
                        off = $urandom_range(0, hl - 1);
                    end else if ($urandom_range(1)) begin
                        off = $urandom_range(4095);
                    end else begin
                        off = hl;
                    end
                    read_at(off);
                end
            end else if (pick < 90) begin
                send_random_of_kind(KIND_RELEASE);
            end else begin
                k = $urandom_range(7);
                if (k == KIND_CANCEL && !allow_cancel) begin
                    k = KIND_DISCARD;
                end
                send_random_of_kind(3'(k));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty ring, one short frame with extreme data, every offset extreme,
    // unknown codes and the release of the only frame.
    task automatic test_single_frame();
        send_cmd(mk_item(KIND_GET, 8'h00, 1'b0, '0));
        read_at(0);
        send_cmd(mk_item(KIND_RELEASE, 8'hFF, 1'b1, '1));
        send_cmd(mk_item(KIND_WRITE, 8'h00, 1'b0, '0));
        send_cmd(mk_item(KIND_WRITE, 8'hFF, 1'b0, '1));
        send_cmd(mk_item(KIND_WRITE, 8'hA5, 1'b1, '0));
        send_cmd(mk_item(KIND_GET, 8'h00, 1'b0, '0));
        read_at(0);
        read_at(2);
        read_at(3);
        read_at(4095);
        send_cmd(mk_item(KIND_UNUSED_6, 8'hFF, 1'b1, '1));
        send_cmd(mk_item(KIND_UNUSED_7, 8'hFF, 1'b1, '1));
        send_cmd(mk_item(KIND_DISCARD, 8'h00, 1'b0, '0));
        send_cmd(mk_item(KIND_RELEASE, 8'h00, 1'b0, '0));
        send_cmd(mk_item(KIND_RELEASE, 8'h00, 1'b0, '0));
    endtask

    // Frame size limit, the smallest room setting, and room settings too big
    // for the smallest store.
    task automatic test_size_limits();
        write_reg(REG_SAFE_SPACE, CFG_W'(12));
        write_frame(5, 1'b0);
        send_cmd(mk_item(KIND_WRITE, 8'h5A, 1'b1, '0));
        send_cmd(mk_item(KIND_DISCARD, 8'h00, 1'b0, '0));
        write_reg(REG_SAFE_SPACE, '0);
        write_frame(1, 1'b1);
        write_reg(REG_BUFFER_BYTES, '0);
        write_reg(REG_SAFE_SPACE, '1);
        write_frame(1, 1'b1);
        write_reg(REG_SAFE_SPACE, CFG_W'(4096));
        write_frame(1, 1'b1);
    endtask

    // Fills the smallest store with one-byte frames until it refuses, then frees
    // enough room at the head for the writer to wrap to word 0.
    task automatic test_wrap_and_full();
        write_reg(REG_BUFFER_BYTES, CFG_W'(67));
        write_reg(REG_SAFE_SPACE, CFG_W'(12));
        repeat (8) write_frame(1, 1'b1);
        send_random_of_kind(KIND_RELEASE);
        write_frame(1, 1'b1);
        send_random_of_kind(KIND_RELEASE);
        write_frame(1, 1'b1);
        send_random_of_kind(KIND_GET);
        read_at(0);
    endtask

    // The four idling mixes, each under its own store and frame sizes.
    task automatic test_random_traffic();
        write_reg(REG_BUFFER_BYTES, '1);
        write_reg(REG_SAFE_SPACE, CFG_W'(40));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_frame_traffic(85, 1'b0);

        write_reg(REG_BUFFER_BYTES, CFG_W'(100));
        write_reg(REG_SAFE_SPACE, CFG_W'(24));
        src_idle_pct   = 87;
        sink_stall_pct = 0;
        run_frame_traffic(85, 1'b0);

        write_reg(REG_BUFFER_BYTES, CFG_W'(64));
        write_reg(REG_SAFE_SPACE, CFG_W'(20));
        src_idle_pct   = 0;
        sink_stall_pct = 87;
        run_frame_traffic(85, 1'b0);

        write_reg(REG_BUFFER_BYTES, CFG_W'(200));
        write_reg(REG_SAFE_SPACE, CFG_W'(48));
        src_idle_pct   = 19;
        sink_stall_pct = 19;
        run_frame_traffic(85, 1'b0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // commands, so the pipeline fills and the input side must stall.
    task automatic test_backpressure();
        write_reg(REG_BUFFER_BYTES, CFG_W'(256));
        write_reg(REG_SAFE_SPACE, CFG_W'(32));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_request   = 300;
        run_frame_traffic(30, 1'b0);
    endtask

    // Cancel is sticky until reset, so this runs last. Writes, gets and reads are
    // refused, while release and discard still work. A register write keeps it.
    task automatic test_cancel();
        write_reg(REG_BUFFER_BYTES, CFG_W'(4096));
        write_reg(REG_SAFE_SPACE, CFG_W'(1024));
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_frame(2, 1'b1);
        send_random_of_kind(KIND_CANCEL);
        write_frame(1, 1'b1);
        send_random_of_kind(KIND_GET);
        read_at(0);
        send_random_of_kind(KIND_RELEASE);
        send_random_of_kind(KIND_RELEASE);
        send_random_of_kind(KIND_DISCARD);
        send_random_of_kind(KIND_CANCEL);
        write_reg(REG_SAFE_SPACE, CFG_W'(16));
        src_idle_pct   = 19;
        sink_stall_pct = 19;
        run_frame_traffic(30, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Receiver ready. A hold-off request is taken over here and counted down one
    // cycle at a time; otherwise ready follows the stall rate of the phase.
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Every result transfer is compared with the oldest expectation. Outputs are
    // sampled at the edge, before the block's own updates of that edge land.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (reply_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: status %0d len %0d data 0x%02h",
                             m_data.status, m_data.frame_length, m_data.data_out);
                end
            end else begin
                want = reply_q.pop_front();
                if (m_data.status !== want.status ||
                    m_data.frame_length !== want.frame_length ||
                    m_data.data_out !== want.data_out) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"mismatch: expected status %0d len %0d data 0x%02h,",
                                  " got status %0d len %0d data 0x%02h"},
                                 want.status, want.frame_length, want.data_out,
                                 m_data.status, m_data.frame_length, m_data.data_out);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        reset_ring_shadow();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_frame();
        test_size_limits();
        test_wrap_and_full();
        test_random_traffic();
        test_backpressure();
        test_cancel();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
